>>> rtl/core/ecacq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecacq_pkg
// Shared constants, types and helpers for the elementary automaton cell query.
// ----------------------------------------------------------------------------
package ecacq_pkg;

  localparam int MAX_GEN = 32;
  localparam int ADDR_W  = $clog2(MAX_GEN);
  localparam int CNT_W   = ADDR_W + 1;
  localparam int ROW_W   = 2 * MAX_GEN - 1;
  localparam int IDX_W   = $clog2(ROW_W);
  localparam int CENTER  = MAX_GEN - 1;
  localparam int POS_W   = IDX_W + 2;
  localparam int RULE_W  = 8;
  localparam int GEN_W   = 5;
  localparam int OFF_W   = 7;

  localparam logic [RULE_W-1:0] RULE_RESET = 8'd30;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BUILD,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic step;
    logic load_seed;
  } row_ctrl_t;

  function automatic logic rule_lookup(input logic [RULE_W-1:0] rule,
                                       input logic l, input logic c, input logic r);
    logic [2:0] hood;
    hood = {l, c, r};
    return rule[hood];
  endfunction

endpackage

>>> rtl/core/ecacq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecacq_cell
// One automaton site: holds its bit and takes the next generation from its
// own bit, its two neighbors and the rule, or loads the seed.
// ----------------------------------------------------------------------------
module ecacq_cell (
  input  logic                          clk,
  input  ecacq_pkg::row_ctrl_t          ctrl,
  input  logic [ecacq_pkg::RULE_W-1:0]  rule,
  input  logic                          seed,
  input  logic                          left,
  input  logic                          right,
  output logic                          value,
  output logic                          value_next
);
  import ecacq_pkg::*;

  assign value_next = ctrl.load_seed ? seed : rule_lookup(rule, left, value, right);

  always_ff @(posedge clk) begin
    if (ctrl.step) begin
      value <= value_next;
    end
  end

endmodule

>>> rtl/core/ecacq_row.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecacq_row
// Chain of sites spanning offsets -CENTER..CENTER plus the background bit.
// Each step advances the whole row by one generation, or loads the seed row.
// ----------------------------------------------------------------------------
module ecacq_row (
  input  logic                          clk,
  input  ecacq_pkg::row_ctrl_t          ctrl,
  input  logic [ecacq_pkg::RULE_W-1:0]  rule,
  output logic [ecacq_pkg::ROW_W-1:0]   frame,
  output logic [ecacq_pkg::ROW_W-1:0]   frame_next,
  output logic                          bg,
  output logic                          bg_next
);
  import ecacq_pkg::*;

  // background sees three background neighbors
  assign bg_next = ctrl.load_seed ? 1'b0 : rule_lookup(rule, bg, bg, bg);

  always_ff @(posedge clk) begin
    if (ctrl.step) begin
      bg <= bg_next;
    end
  end

  for (genvar i = 0; i < ROW_W; i++) begin : g_site
    logic left_n;
    logic right_n;

    if (i == 0) begin : g_lo
      assign left_n = bg;
    end else begin : g_lo
      assign left_n = frame[i-1];
    end

    if (i == ROW_W - 1) begin : g_hi
      assign right_n = bg;
    end else begin : g_hi
      assign right_n = frame[i+1];
    end

    ecacq_cell u_site (
      .clk        (clk),
      .ctrl       (ctrl),
      .rule       (rule),
      .seed       ((i == CENTER) ? 1'b1 : 1'b0),
      .left       (left_n),
      .right      (right_n),
      .value      (frame[i]),
      .value_next (frame_next[i])
    );
  end

endmodule

>>> rtl/core/elementary_ca_cell_query.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elementary_ca_cell_query
// Answers (generation, offset) queries on an elementary automaton, building
// and storing generations on demand.
// ----------------------------------------------------------------------------
//  channel   handshake                 payload
//  query     start / busy              generation, cell_offset
//  result    done (strobe)             cell_value, outside_row
//  config    cfg_valid / cfg_ready     rule_number
//
//  A query whose generation is already stored reads the row memory in the
//  accept cycle, and the result strobes in the next.
//  A query beyond the stored depth first takes one step of the cell chain
//  per missing generation (up to MAX_GEN); the result then comes
//  straight from the chain. A rule write drops all stored generations and
//  is held off while a query is in flight.
//  Reset restores rule 30 and an empty store; no clearing pass is needed.
//  Results cannot be stalled; done is high for exactly one cycle.
// ----------------------------------------------------------------------------
module elementary_ca_cell_query (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic [ecacq_pkg::GEN_W-1:0]        generation,
  input  logic signed [ecacq_pkg::OFF_W-1:0] cell_offset,
  output logic                               done,
  output logic                               cell_value,
  output logic                               outside_row,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ecacq_pkg::RULE_W-1:0]       rule_number
);
  import ecacq_pkg::*;

  state_t                   state;
  state_t                   state_next;
  logic [RULE_W-1:0]        rule;
  logic [CNT_W-1:0]         built_count;
  logic [ADDR_W-1:0]        q_gen;
  logic signed [OFF_W-1:0]  q_off;
  logic                     use_chain;

  logic                     accept;
  logic                     cfg_wr;
  logic [ADDR_W-1:0]        gen_sat;
  logic                     have_row;
  row_ctrl_t                row_ctrl;

  logic [ROW_W-1:0]         frame;
  logic [ROW_W-1:0]         frame_next;
  logic                     bg;
  logic                     bg_next;

  logic [ROW_W:0]           mem [MAX_GEN];
  logic [ROW_W:0]           rd_data;

  logic [ROW_W-1:0]         sel_frame;
  logic                     sel_bg;
  logic signed [POS_W-1:0]  off_ext;
  logic signed [POS_W-1:0]  gen_ext;
  logic signed [POS_W-1:0]  pos;
  logic                     in_row;

  // hold rule writes off while a query is in flight
  assign cfg_ready = !busy;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign busy      = (state != ST_IDLE);
  assign accept    = start && !busy;

  // clamp the generation to the stored depth
  always_comb begin
    if ({{(CNT_W-GEN_W){1'b0}}, generation} >= CNT_W'(MAX_GEN)) begin
      gen_sat = ADDR_W'(MAX_GEN - 1);
    end else begin
      gen_sat = generation[ADDR_W-1:0];
    end
  end

  assign have_row = (built_count > {1'b0, gen_sat});

  assign row_ctrl.step      = (state == ST_BUILD);
  assign row_ctrl.load_seed = (built_count == '0);

  ecacq_row u_row (
    .clk        (clk),
    .ctrl       (row_ctrl),
    .rule       (rule),
    .frame      (frame),
    .frame_next (frame_next),
    .bg         (bg),
    .bg_next    (bg_next)
  );

  // row store: written while building, read at the incoming generation
  always_ff @(posedge clk) begin
    if (state == ST_BUILD) begin
      mem[built_count[ADDR_W-1:0]] <= {bg_next, frame_next};
    end
    rd_data <= mem[gen_sat];
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = have_row ? ST_OUT : ST_BUILD;
        end
      end
      ST_BUILD: begin
        if (built_count == {1'b0, q_gen}) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT:  state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      rule        <= RULE_RESET;
      built_count <= '0;
    end else begin
      state <= state_next;
      if (cfg_wr) begin
        rule        <= rule_number;
        built_count <= '0;
      end else if (state == ST_BUILD) begin
        built_count <= built_count + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q_gen     <= gen_sat;
      q_off     <= cell_offset;
      use_chain <= !have_row;
    end
  end

  // result: from the chain after a build, else from the store
  always_comb begin
    sel_frame = use_chain ? frame : rd_data[ROW_W-1:0];
    sel_bg    = use_chain ? bg : rd_data[ROW_W];
    off_ext   = POS_W'(q_off);
    gen_ext   = POS_W'(signed'({1'b0, q_gen}));
    pos       = off_ext + POS_W'(CENTER);
    in_row    = (off_ext <= gen_ext) && (off_ext >= -gen_ext);
  end

  always_comb begin
    done = (state == ST_OUT);
    if (in_row) begin
      cell_value  = sel_frame[pos[IDX_W-1:0]];
      outside_row = 1'b0;
    end else begin
      cell_value  = sel_bg;
      outside_row = 1'b1;
    end
  end

`ifndef SYNTH
  a_build_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_BUILD) |=> (built_count == $past(built_count) + CNT_W'(1)))
    else $error("built_count did not advance during build");

  a_build_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_BUILD) |-> (built_count <= {1'b0, q_gen}))
    else $error("build ran past the queried generation");

  a_done_built: assert property (@(posedge clk) disable iff (rst)
    done |-> (built_count > {1'b0, q_gen}))
    else $error("result given before its generation was built");

  a_cfg_clear: assert property (@(posedge clk) disable iff (rst)
    cfg_wr |=> (built_count == '0))
    else $error("rule write did not drop stored generations");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("accepted item did not raise busy");
`endif

endmodule

>>> dv/elementary_ca_cell_query_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elementary_ca_cell_query_checker
// Watches the query, result and rule channels of the cell query block. It
// keeps its own copy of the automaton rows, predicts each queried cell and
// compares every result strobe with the oldest predicted answer.
// ----------------------------------------------------------------------------
module elementary_ca_cell_query_checker (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic                               busy,
  input  logic [ecacq_pkg::GEN_W-1:0]        generation,
  input  logic signed [ecacq_pkg::OFF_W-1:0] cell_offset,
  input  logic                               done,
  input  logic                               cell_value,
  input  logic                               outside_row,
  input  logic                               cfg_valid,
  input  logic                               cfg_ready,
  input  logic [ecacq_pkg::RULE_W-1:0]       rule_number,
  output int                                 outstanding,
  output int                                 fail_count
);
  import ecacq_pkg::*;

  typedef struct packed {
    logic cell_value;
    logic outside_row;
  } answer_t;

  logic [RULE_W-1:0] rule_q;
  logic [ROW_W-1:0]  row_mem [MAX_GEN];
  logic              bg_mem [MAX_GEN];
  int                rows_built;
  int                mismatches;
  answer_t           answers_due [$];

  // Cell at row index p of stored generation n; background outside the row.
  function automatic logic cell_of(int n, int p);
    if (p < 0 || p > 2 * n) return bg_mem[n];
    return row_mem[n][p];
  endfunction

  function automatic void grow_row(int n);
    logic [ROW_W-1:0] row;
    row = '0;
    if (n == 0) begin
      row_mem[0] = ROW_W'(1);
      bg_mem[0]  = 1'b0;
      return;
    end
    for (int i = 0; i <= 2 * n; i++) begin
      row[i] = rule_q[{cell_of(n - 1, i - 2), cell_of(n - 1, i - 1), cell_of(n - 1, i)}];
    end
    row_mem[n] = row;
    bg_mem[n]  = rule_q[{3{bg_mem[n - 1]}}];
  endfunction

  function automatic answer_t predict_cell(int g, int x);
    answer_t ans;
    int      ax;
    while (rows_built <= g) begin
      grow_row(rows_built);
      rows_built++;
    end
    ax = (x < 0) ? -x : x;
    if (ax > g) begin
      ans.cell_value  = bg_mem[g];
      ans.outside_row = 1'b1;
    end else begin
      ans.cell_value  = row_mem[g][x + g];
      ans.outside_row = 1'b0;
    end
    return ans;
  endfunction

  always @(posedge clk) begin
    answer_t want;
    if (rst) begin
      rule_q     = RULE_RESET;
      rows_built = 0;
      answers_due.delete();
    end else begin
      if (done) begin
        if (answers_due.size() == 0) begin
          $display("%0t: unexpected result: cell_value=%0b outside_row=%0b",
                   $time, cell_value, outside_row);
          mismatches++;
        end else begin
          want = answers_due.pop_front();
          if (cell_value !== want.cell_value) begin
            $display("%0t: cell_value mismatch: expected %0b, actual %0b",
                     $time, want.cell_value, cell_value);
            mismatches++;
          end
          if (outside_row !== want.outside_row) begin
            $display("%0t: outside_row mismatch: expected %0b, actual %0b",
                     $time, want.outside_row, outside_row);
            mismatches++;
          end
        end
      end
      // A new rule drops every stored generation.
      if (cfg_valid && cfg_ready) begin
        rule_q     = rule_number;
        rows_built = 0;
      end
      if (start && !busy) answers_due = {answers_due, predict_cell(generation, cell_offset)};
    end
    outstanding <= answers_due.size();
    fail_count  <= mismatches;
  end

endmodule

>>> dv/elementary_ca_cell_query_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elementary_ca_cell_query_test
// Drives directed and random cell queries under a series of rules, with
// random gaps, bursts and drains between items; the checker beside the block
// predicts and compares every result.
// ----------------------------------------------------------------------------
module elementary_ca_cell_query_test;
  import ecacq_pkg::*;

  localparam int STALL_LIMIT     = 2000;
  localparam int PHASES          = 10;
  localparam int ITEMS_PER_PHASE = 123;
  localparam int DIRECTED        = 18;

  logic                     clk = 1'b0;
  logic                     rst;
  logic                     start;
  logic                     busy;
  logic [GEN_W-1:0]         generation;
  logic signed [OFF_W-1:0]  cell_offset;
  logic                     done;
  logic                     cell_value;
  logic                     outside_row;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [RULE_W-1:0]        rule_number;
  int                       outstanding;
  int                       fail_count;
  int                       idle_cycles = 0;

  logic [RULE_W-1:0] rule_plan [8] = '{8'd0, 8'd255, 8'd1, 8'd90, 8'd110, 8'd73, 8'd184, 8'd30};
  int dir_gen [DIRECTED] = '{0, 0, 0, 0, 0, 31, 31, 31, 31, 31, 31, 31, 1, 1, 1, 3, 15, 2};
  int dir_off [DIRECTED] = '{0, 1, -1, 63, -64, 0, 31, -31, 32, -32, 63, -64, -1, 1, 2, -3,
                             7, 0};

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  elementary_ca_cell_query i_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .generation  (generation),
    .cell_offset (cell_offset),
    .done        (done),
    .cell_value  (cell_value),
    .outside_row (outside_row),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .rule_number (rule_number)
  );

  elementary_ca_cell_query_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .generation  (generation),
    .cell_offset (cell_offset),
    .done        (done),
    .cell_value  (cell_value),
    .outside_row (outside_row),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .rule_number (rule_number),
    .outstanding (outstanding),
    .fail_count  (fail_count)
  );

  // Count cycles in which no channel moves anything.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("elementary_ca_cell_query_test failed");
        $finish;
      end
    end
  end

  // Hold start across back-to-back items; drop it only for a gap.
  task automatic send_query(input int g, input int x, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start       <= 1'b1;
    generation  <= g[GEN_W-1:0];
    cell_offset <= x[OFF_W-1:0];
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic random_query(input int gap);
    int g;
    int x;
    g = $urandom_range(0, 31);
    // Mostly cells inside the row, the rest anywhere in the offset range.
    if ($urandom_range(0, 3) != 0) x = int'($urandom_range(0, 2 * g)) - g;
    else x = int'($urandom_range(0, 127)) - 64;
    send_query(g, x, gap);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_rule(input logic [RULE_W-1:0] rule);
    cfg_valid   <= 1'b1;
    rule_number <= rule;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [RULE_W-1:0] rule;
    logic              quiet;
    rst         = 1'b1;
    start       = 1'b0;
    generation  = '0;
    cell_offset = '0;
    cfg_valid   = 1'b0;
    rule_number = RULE_RESET;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Extremes of both fields under the reset rule.
    for (int i = 0; i < DIRECTED; i++) send_query(dir_gen[i], dir_off[i], $urandom_range(0, 2));

    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      rule = (p < 8) ? rule_plan[p] : RULE_W'($urandom_range(0, 255));
      write_rule(rule);
      quiet = (p % 3 == 2);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (!quiet && $urandom_range(0, 39) == 0) wait_drained();
        random_query(quiet ? 0 : $urandom_range(0, 16));
      end
    end

    wait_drained();
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("elementary_ca_cell_query_test passed");
    end else begin
      $display("elementary_ca_cell_query_test failed");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/ecacq_pkg.sv
rtl/core/ecacq_cell.sv
rtl/core/ecacq_row.sv
rtl/core/elementary_ca_cell_query.sv
dv/elementary_ca_cell_query_checker.sv
dv/elementary_ca_cell_query_test.sv
